// File: design/direct_mapped_presence_cache_macros.svh
// Assertion helpers for the presence cache. Each use expects clk and rst_n in scope.
`ifndef DIRECT_MAPPED_PRESENCE_CACHE_MACROS_SVH
`define DIRECT_MAPPED_PRESENCE_CACHE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DMPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmpc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DMPC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmpc: next-cycle check failed");

`endif

// File: design/dmpc_pkg.sv
package dmpc_pkg;

    localparam int CFG_W     = 11;
    localparam int HASH_W    = 64;
    localparam int CNT_W     = 32;
    localparam int KIND_W    = 2;
    localparam int OUTCOME_W = 2;
    localparam int SLOT_W    = 32;
    localparam int DIV_CNT_W = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP     = 2'd0,
        KIND_FILL       = 2'd1,
        KIND_WRITE      = 2'd2,
        KIND_READ_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT_PRESENT = 2'd0,
        OUT_HIT_ABSENT  = 2'd1,
        OUT_NOT_CACHED  = 2'd2,
        OUT_NO_LOOKUP   = 2'd3
    } outcome_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic div_step;
        logic mem_rd;
        logic finish;
        logic clr_step;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_valid;
        logic in_needs_slot;
        logic div_last;
        logic clr_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// File: design/dmpc_if.sv
interface dmpc_req_if;
    logic                             valid;
    logic                             ready;
    logic [dmpc_pkg::KIND_W-1:0]      kind;
    logic [dmpc_pkg::HASH_W-1:0]      hash_high;
    logic [dmpc_pkg::HASH_W-1:0]      hash_low;
    logic                             found_flag;

    modport source (output valid, kind, hash_high, hash_low, found_flag, input ready);
    modport sink   (input valid, kind, hash_high, hash_low, found_flag, output ready);
endinterface

interface dmpc_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [dmpc_pkg::OUTCOME_W-1:0]   outcome;
    logic [dmpc_pkg::CNT_W-1:0]       count_hit_present;
    logic [dmpc_pkg::CNT_W-1:0]       count_hit_absent;
    logic [dmpc_pkg::CNT_W-1:0]       count_miss_present;
    logic [dmpc_pkg::CNT_W-1:0]       count_miss_absent;

    modport source (output valid, outcome, count_hit_present, count_hit_absent,
                    count_miss_present, count_miss_absent, input ready);
    modport sink   (input valid, outcome, count_hit_present, count_hit_absent,
                    count_miss_present, count_miss_absent, output ready);
endinterface

// File: design/direct_mapped_presence_cache.sv
// Lookup, fill or write with the cache enabled: remainder, slot read, then result registered.
// Counter read, or any request with the cache disabled: result registered without a slot read.
// A request is taken only after the last one's update step; the 32-step remainder unit dominates.
// After reset and after each size write, a sweep zeroes every slot in turn; no request is
// accepted until it ends. Reset also zeroes the size (cache disabled) and counters.
module direct_mapped_presence_cache
#(
    parameter int MAX_ENTRIES = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [dmpc_pkg::CFG_W-1:0]  cfg_wr_data,
    dmpc_req_if.sink                    req,
    dmpc_rsp_if.source                  rsp
);

    // Controller and datapath talk only through these two bundles.
    dmpc_pkg::dp_cmd_t    cmd;
    dmpc_pkg::dp_status_t status;

    // Sequencer: sweep, accept a request, run the slot remainder bit by bit,
    // read the slot, then update the slot and counters and hand the result
    // to the output register. A pending result does not block acceptance;
    // only the final update step waits for the output register to free up.
    dmpc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: request registers, remainder unit (hash bits 63..32 of the
    // low word modulo the size), the slot memory with its registered read
    // port, the four saturating counters and the output register.
    dmpc_dp
    #(
        .MAX_ENTRIES (MAX_ENTRIES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// File: design/dmpc_ctrl.sv
`include "direct_mapped_presence_cache_macros.svh"

module dmpc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  dmpc_pkg::dp_status_t status,
    output dmpc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DIVIDE = 5'b00100,
        S_READ   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (status.req_valid)
                begin
                    state_next = status.in_needs_slot ? S_DIVIDE : S_FINISH;
                end
            end
            S_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        // a size write restarts the sweep from any state
        if (cfg_wr_en)
        begin
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.in_ready = (state_reg == S_IDLE) && !cfg_wr_en;
        cmd.div_step = (state_reg == S_DIVIDE);
        cmd.mem_rd   = (state_reg == S_READ);
        cmd.finish   = (state_reg == S_FINISH) && status.out_free;
        cmd.clr_step = (state_reg == S_CLEAR);
    end

    `DMPC_ASSERT_NXT(a_cfg_starts_clear, cfg_wr_en, state_reg == S_CLEAR)
    `DMPC_ASSERT_NXT(a_divide_to_read, state_reg == S_DIVIDE && status.div_last && !cfg_wr_en, state_reg == S_READ)

endmodule

// File: design/dmpc_dp.sv
`include "direct_mapped_presence_cache_macros.svh"

module dmpc_dp
#(
    parameter int MAX_ENTRIES = 1024
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dmpc_pkg::CFG_W-1:0]       cfg_wr_data,
    dmpc_req_if.sink                         req,
    dmpc_rsp_if.source                       rsp,
    input  dmpc_pkg::dp_cmd_t                cmd,
    output dmpc_pkg::dp_status_t             status
);

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TAG_W   = 2 * dmpc_pkg::HASH_W;
    localparam int ENTRY_W = TAG_W + 1;
    localparam int CW      = dmpc_pkg::CFG_W;
    localparam int NW      = dmpc_pkg::CNT_W;
    localparam int HW      = dmpc_pkg::HASH_W;
    localparam int SW      = dmpc_pkg::SLOT_W;

    localparam logic [16:0]      MAX_LIM  = 17'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    // control state
    logic [CW-1:0]                 entries_reg;
    logic [dmpc_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [IDX_W-1:0]              clr_idx_reg;
    logic                          out_valid_reg;
    logic [NW-1:0]                 hit_pres_reg;
    logic [NW-1:0]                 hit_abs_reg;
    logic [NW-1:0]                 miss_pres_reg;
    logic [NW-1:0]                 miss_abs_reg;
    logic [NW-1:0]                 hit_pres_next;
    logic [NW-1:0]                 hit_abs_next;
    logic [NW-1:0]                 miss_pres_next;
    logic [NW-1:0]                 miss_abs_next;

    // payload
    dmpc_pkg::kind_t               kind_reg;
    logic [HW-1:0]                 hash_hi_reg;
    logic [HW-1:0]                 hash_lo_reg;
    logic                          found_reg;
    logic [SW-1:0]                 quo_reg;
    logic [CW-1:0]                 rem_reg;
    logic [CW-1:0]                 rem_next;
    logic [ENTRY_W-1:0]            rd_entry_reg;
    dmpc_pkg::outcome_t            outcome_reg;
    dmpc_pkg::outcome_t            outcome_next;
    logic [NW-1:0]                 out_hp_reg;
    logic [NW-1:0]                 out_ha_reg;
    logic [NW-1:0]                 out_mp_reg;
    logic [NW-1:0]                 out_ma_reg;

    logic [ENTRY_W-1:0]            mem [MAX_ENTRIES];

    logic                          accept;
    logic                          enabled;
    logic [CW:0]                   trial;
    logic [IDX_W-1:0]              slot;
    logic                          match;
    logic                          mark;
    logic                          hit;
    logic                          store_en;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [ENTRY_W-1:0]            mem_wdata;
    logic [CW-1:0]                 entries_sat;

    assign accept  = req.valid && cmd.in_ready;
    assign enabled = (entries_reg != '0);

    assign entries_sat = ({6'b0, cfg_wr_data} > MAX_LIM) ? CW'(MAX_ENTRIES) : cfg_wr_data;

    // restoring remainder, one dividend bit per step
    assign trial = {rem_reg, quo_reg[SW-1]};
    always_comb
    begin
        if (trial >= {1'b0, entries_reg})
        begin
            rem_next = CW'(trial - {1'b0, entries_reg});
        end
        else
        begin
            rem_next = trial[CW-1:0];
        end
    end

    assign slot  = IDX_W'(rem_reg);
    assign match = (rd_entry_reg[TAG_W-1:0] == {hash_hi_reg, hash_lo_reg});
    assign mark  = rd_entry_reg[TAG_W];
    assign hit   = enabled && match;

    assign store_en  = cmd.finish && enabled &&
                       (kind_reg == dmpc_pkg::KIND_FILL || kind_reg == dmpc_pkg::KIND_WRITE);
    assign mem_we    = cmd.clr_step || store_en;
    assign mem_waddr = cmd.clr_step ? clr_idx_reg : slot;
    assign mem_wdata = cmd.clr_step ? '0 :
                       {(kind_reg == dmpc_pkg::KIND_WRITE) ? 1'b1 : found_reg,
                        hash_hi_reg, hash_lo_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_entry_reg <= mem[slot];
        end
    end

    always_comb
    begin
        case (kind_reg)
            dmpc_pkg::KIND_LOOKUP:
            begin
                if (hit)
                begin
                    outcome_next = mark ? dmpc_pkg::OUT_HIT_PRESENT : dmpc_pkg::OUT_HIT_ABSENT;
                end
                else
                begin
                    outcome_next = dmpc_pkg::OUT_NOT_CACHED;
                end
            end
            default:
            begin
                outcome_next = dmpc_pkg::OUT_NO_LOOKUP;
            end
        endcase
    end

    always_comb
    begin
        hit_pres_next  = hit_pres_reg;
        hit_abs_next   = hit_abs_reg;
        miss_pres_next = miss_pres_reg;
        miss_abs_next  = miss_abs_reg;
        if (cfg_wr_en)
        begin
            hit_pres_next  = '0;
            hit_abs_next   = '0;
            miss_pres_next = '0;
            miss_abs_next  = '0;
        end
        else if (cmd.finish)
        begin
            case (kind_reg)
                dmpc_pkg::KIND_LOOKUP:
                begin
                    if (hit && mark)
                    begin
                        hit_pres_next = dmpc_pkg::sat_inc(hit_pres_reg);
                    end
                    else if (hit)
                    begin
                        hit_abs_next = dmpc_pkg::sat_inc(hit_abs_reg);
                    end
                end
                dmpc_pkg::KIND_FILL:
                begin
                    if (found_reg)
                    begin
                        miss_pres_next = dmpc_pkg::sat_inc(miss_pres_reg);
                    end
                    else
                    begin
                        miss_abs_next = dmpc_pkg::sat_inc(miss_abs_reg);
                    end
                end
                dmpc_pkg::KIND_READ_CLEAR:
                begin
                    hit_pres_next  = '0;
                    hit_abs_next   = '0;
                    miss_pres_next = '0;
                    miss_abs_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= '0;
            div_cnt_reg   <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_pres_reg  <= '0;
            hit_abs_reg   <= '0;
            miss_pres_reg <= '0;
            miss_abs_reg  <= '0;
        end
        else
        begin
            hit_pres_reg  <= hit_pres_next;
            hit_abs_reg   <= hit_abs_next;
            miss_pres_reg <= miss_pres_next;
            miss_abs_reg  <= miss_abs_next;
            if (cfg_wr_en)
            begin
                entries_reg <= entries_sat;
            end
            if (accept)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                clr_idx_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_idx_reg <= (clr_idx_reg == LAST_IDX) ? '0 : clr_idx_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= dmpc_pkg::kind_t'(req.kind);
            hash_hi_reg <= req.hash_high;
            hash_lo_reg <= req.hash_low;
            found_reg   <= req.found_flag;
            quo_reg     <= req.hash_low[HW-1:HW-SW];
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.finish)
        begin
            outcome_reg <= outcome_next;
            if (kind_reg == dmpc_pkg::KIND_READ_CLEAR)
            begin
                out_hp_reg <= hit_pres_reg;
                out_ha_reg <= hit_abs_reg;
                out_mp_reg <= miss_pres_reg;
                out_ma_reg <= miss_abs_reg;
            end
            else
            begin
                out_hp_reg <= '0;
                out_ha_reg <= '0;
                out_mp_reg <= '0;
                out_ma_reg <= '0;
            end
        end
    end

    assign req.ready              = cmd.in_ready;
    assign rsp.valid              = out_valid_reg;
    assign rsp.outcome            = outcome_reg;
    assign rsp.count_hit_present  = out_hp_reg;
    assign rsp.count_hit_absent   = out_ha_reg;
    assign rsp.count_miss_present = out_mp_reg;
    assign rsp.count_miss_absent  = out_ma_reg;

    always_comb
    begin
        status.req_valid     = req.valid;
        status.in_needs_slot = (dmpc_pkg::kind_t'(req.kind) != dmpc_pkg::KIND_READ_CLEAR) && enabled;
        status.div_last      = (div_cnt_reg == '1);
        status.clr_last      = (clr_idx_reg == LAST_IDX);
        status.out_free      = !out_valid_reg || rsp.ready;
    end

    `DMPC_ASSERT_IMP(a_finish_no_overwrite, cmd.finish, !out_valid_reg || rsp.ready)
    `DMPC_ASSERT_NXT(a_rem_below_size, cmd.div_step && !cfg_wr_en, rem_reg < entries_reg)

endmodule
